[sv/ctp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants of the countdown timer pool
// Operation codes, field widths and the divide-by-20 reciprocal.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int TIMERS_DEFAULT = 32;

  localparam int OP_W    = 2;
  localparam int ID_W    = 5;
  localparam int MS_W    = 32;
  localparam int TICKS_W = 28;
  localparam int COUNT_W = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

  // x / 20 == (x * ceil(2^34 / 5)) >> 36 for every 32-bit x
  localparam logic [MS_W-1:0] DIV20_RECIP = 32'hCCCC_CCCD;
  localparam int              DIV20_SHIFT = 36;

  typedef logic [TICKS_W-1:0] ticks_t;

endpackage

[sv/ctp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_if: request and response channels of the countdown timer pool
// Valid/ready channels carrying one operation and one result.
// ----------------------------------------------------------------------------
interface ctp_req_if;
  logic                         valid;
  logic                         ready;
  logic [ctp_pkg::OP_W-1:0]     operation;
  logic [ctp_pkg::ID_W-1:0]     timer_id;
  logic [ctp_pkg::MS_W-1:0]     duration_ms;

  modport source (output valid, operation, timer_id, duration_ms, input ready);
  modport sink   (input valid, operation, timer_id, duration_ms, output ready);
endinterface

interface ctp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ctp_pkg::ID_W-1:0]     granted_id;
  logic                         pool_full;
  logic                         timed_out;
  logic                         not_registered;
  logic [ctp_pkg::COUNT_W-1:0]  tick_count;

  modport source (output valid, granted_id, pool_full, timed_out, not_registered,
                  tick_count, input ready);
  modport sink   (input valid, granted_id, pool_full, timed_out, not_registered,
                  tick_count, output ready);
endinterface
`default_nettype wire

[sv/ctp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/ctp_dec_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_dec_unit: shared zero test and decrement
// Used by the tick walk and by the timeout check.
// ----------------------------------------------------------------------------
module ctp_dec_unit (
  input  wire logic            [ctp_pkg::TICKS_W-1:0] cur,
  output logic                                        is_zero,
  output ctp_pkg::ticks_t                             dec
);
  assign is_zero = (cur == '0);
  assign dec     = cur - ctp_pkg::TICKS_W'(1);
endmodule
`default_nettype wire

[sv/countdown_timer_pool.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// countdown_timer_pool: pool of countdown timers with an allocation bitmap
// Allocate, start, tick and check-and-release over TIMERS countdown timers.
// ----------------------------------------------------------------------------
// req carries one operation (allocate, start, tick, check); rsp returns one
// result for each request, in order. Only one request is in work at a time:
// req.ready is high while the sequencer is idle.
// Steps from accept to a valid result:
//   allocate: bitmap scanned one timer per cycle
//   start:    reciprocal multiply, then one store write
//   tick:     read-modify-write walk over the count store
//   check:    one store read, then the shared zero test
// The timer walk and the single count store port shape these steps. The next
// request is taken in the cycle after a result is loaded. The result sits in
// an output register, so the next request is taken while an earlier result
// still waits; a stalled rsp holds its result, and a finished request waits
// in its last step until the output register frees up.
// Reset clears the tick count, frees every timer and marks every stored count
// as zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module countdown_timer_pool #(
  parameter int TIMERS = ctp_pkg::TIMERS_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  ctp_req_if.sink    req,
  ctp_rsp_if.source  rsp
);
  localparam int ID_W    = ctp_pkg::ID_W;
  localparam int IDL_W   = ctp_pkg::ID_W + 1;
  localparam int TICKS_W = ctp_pkg::TICKS_W;
  localparam int COUNT_W = ctp_pkg::COUNT_W;
  localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W   = $clog2(TIMERS + 1);

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TIMERS);
  localparam logic [IDL_W-1:0] ID_LIMIT = IDL_W'(TIMERS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ALLOC    = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_START_WR = 3'd3;
  localparam logic [2:0] S_TICK     = 3'd4;
  localparam logic [2:0] S_CHK_RD   = 3'd5;
  localparam logic [2:0] S_CHK_EVAL = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                 state;
  logic [ID_W-1:0]            id_q;
  logic [ctp_pkg::MS_W-1:0]   ms_q;
  ctp_pkg::ticks_t            quot;
  logic [CNT_W-1:0]           cnt;
  logic                       pend;
  logic [IDX_W-1:0]           pend_idx;
  logic [TIMERS-1:0]          in_use;
  logic [TIMERS-1:0]          vld;
  logic [COUNT_W-1:0]         elapsed;

  logic [ID_W-1:0]            res_granted;
  logic                       res_full;
  logic                       res_tout;
  logic                       res_notreg;

  logic                       out_valid;
  logic [ID_W-1:0]            out_granted;
  logic                       out_full;
  logic                       out_tout;
  logic                       out_notreg;
  logic [COUNT_W-1:0]         out_ticks;

  logic [IDX_W-1:0]           id_idx;
  logic [IDX_W-1:0]           cnt_idx;
  logic                       reg_hit;
  logic [63:0]                prod;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  ctp_pkg::ticks_t            ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  ctp_pkg::ticks_t            ram_rdata;
  ctp_pkg::ticks_t            rd_cur;
  logic                       is_zero;
  ctp_pkg::ticks_t            dec;

  assign id_idx  = id_q[IDX_W-1:0];
  assign cnt_idx = cnt[IDX_W-1:0];
  assign reg_hit = ({1'b0, id_q} < ID_LIMIT) && in_use[id_idx];
  assign prod    = {32'b0, ms_q} * {32'b0, ctp_pkg::DIV20_RECIP};

  // a never-written entry reads as zero
  assign rd_cur = vld[pend_idx] ? ram_rdata : '0;

  ctp_dec_unit u_dec (
    .cur     (rd_cur),
    .is_zero (is_zero),
    .dec     (dec)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = dec;
    ram_raddr = id_idx;
    unique case (state)
      S_START_WR: begin
        ram_we    = 1'b1;
        ram_waddr = id_idx;
        ram_wdata = quot;
      end
      S_TICK: begin
        ram_raddr = cnt_idx;
        ram_we    = pend && in_use[pend_idx] && !is_zero;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ctp_ram #(
    .WIDTH (TICKS_W),
    .DEPTH (TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.granted_id     = out_granted;
  assign rsp.pool_full      = out_full;
  assign rsp.timed_out      = out_tout;
  assign rsp.not_registered = out_notreg;
  assign rsp.tick_count     = out_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      vld       <= '0;
      elapsed   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      // the done step reloads the output register itself
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            id_q        <= req.timer_id;
            ms_q        <= req.duration_ms;
            cnt         <= '0;
            pend        <= 1'b0;
            res_granted <= '0;
            res_full    <= 1'b0;
            res_tout    <= 1'b0;
            res_notreg  <= 1'b0;
            unique case (req.operation)
              ctp_pkg::OP_ALLOC: state <= S_ALLOC;
              ctp_pkg::OP_START: state <= S_MUL;
              ctp_pkg::OP_TICK: begin
                elapsed <= elapsed + COUNT_W'(1);
                state   <= S_TICK;
              end
              ctp_pkg::OP_CHECK: state <= S_CHK_RD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ALLOC: begin
          if (cnt == CNT_END) begin
            res_full <= 1'b1;
            state    <= S_DONE;
          end else if (!in_use[cnt_idx]) begin
            in_use[cnt_idx] <= 1'b1;
            res_granted     <= ID_W'(cnt);
            state           <= S_DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_MUL: begin
          quot <= prod[ctp_pkg::DIV20_SHIFT +: TICKS_W];
          if (reg_hit) begin
            state <= S_START_WR;
          end else begin
            res_notreg <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_START_WR: begin
          state <= S_DONE;
        end
        S_TICK: begin
          // read entry cnt while writing back entry cnt - 1
          if (cnt == CNT_END) begin
            pend  <= 1'b0;
            state <= S_DONE;
          end else begin
            pend     <= 1'b1;
            pend_idx <= cnt_idx;
            cnt      <= cnt + CNT_W'(1);
          end
        end
        S_CHK_RD: begin
          if (reg_hit) begin
            pend_idx <= id_idx;
            state    <= S_CHK_EVAL;
          end else begin
            res_notreg <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_CHK_EVAL: begin
          if (is_zero) begin
            in_use[pend_idx] <= 1'b0;
            res_tout         <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_granted <= res_granted;
            out_full    <= res_full;
            out_tout    <= res_tout;
            out_notreg  <= res_notreg;
            out_ticks   <= elapsed;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_store_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE))
    else $error("count store written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("accepted request did not start work");

  a_tick_count_step: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == ctp_pkg::OP_TICK)
      |=> (elapsed == $past(elapsed) + COUNT_W'(1)))
    else $error("tick count did not advance on tick");

  a_timeout_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK_EVAL && is_zero) |=> !in_use[pend_idx])
    else $error("timed-out timer not released");

endmodule
`default_nettype wire
